/* rtl/drrip_stream_bypass_replacement_defines.svh */
// assertion macros shared by the rrip replacement rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef DRRIP_STREAM_BYPASS_REPLACEMENT_DEFINES_SVH
`define DRRIP_STREAM_BYPASS_REPLACEMENT_DEFINES_SVH

// plain property, checked every clock outside reset
`define DRRIP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DRRIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/drrip_pkg.sv */
// shared codes, constants and controller/datapath handshake structs
// depends on nothing
`default_nettype none

package drrip_pkg;

  // request kinds
  localparam logic [1:0] REQ_VICTIM = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_EVICT  = 2'd2;

  // re-reference values
  localparam logic [1:0] RRPV_HIT  = 2'd0;
  localparam logic [1:0] RRPV_NEAR = 2'd1;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_MAX  = 2'd3;

  // duel counter limits
  localparam logic [9:0] DUEL_MID = 10'd512;
  localparam logic [9:0] DUEL_TOP = 10'd1023;

  localparam int ADDR_W = 64;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic exec;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/drrip_ctrl.sv */
// sequencing state machine: clearing pass, request accept, execute
// depends on drrip_pkg
`default_nettype none

module drrip_ctrl
  import drrip_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous result is still waiting
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/drrip_dp.sv */
// datapath: per-set row memory, victim aging, stream detector, duel counter
// depends on drrip_pkg and drrip_stream_bypass_replacement_defines.svh
`default_nettype none

`include "drrip_stream_bypass_replacement_defines.svh"

module drrip_dp
  import drrip_pkg::*;
#(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int LEADER_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [1:0]  req_type,
  input  wire logic [10:0] set_index,
  input  wire logic [3:0]  way_index,
  input  wire logic [63:0] phys_addr,
  input  wire logic        hit_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       victim_way,
  output logic             stream_flag
);

  localparam int SW       = $clog2(NUM_SETS);
  localparam int PW       = $clog2(NUM_WAYS);
  localparam int RV_W     = 2 * NUM_WAYS;
  localparam int CNT_LO   = RV_W;
  localparam int STR_LO   = RV_W + 2;
  localparam int ADR_LO   = STR_LO + ADDR_W;
  localparam int RW       = ADR_LO + ADDR_W;
  localparam int BRRIP_LO = (NUM_SETS > LEADER_COUNT) ? NUM_SETS - LEADER_COUNT : 0;
  localparam logic [RW-1:0] RESET_ROW = RW'({RV_W{1'b1}});

  // row memory: rrpv of all ways, stream count, last stride, last address
  logic [RW-1:0] mem [NUM_SETS];
  logic [RW-1:0] rd_row;
  logic [RW-1:0] row_new;
  logic          row_wr;

  logic [SW-1:0] clr_addr;
  logic [SW-1:0] set_addr;
  logic [19:0]   set_rem;

  // request registers
  logic [1:0]        req_r;
  logic [SW-1:0]     set_r;
  logic [3:0]        way_r;
  logic [ADDR_W-1:0] addr_r;
  logic              hit_r;
  logic              lead_s;
  logic              lead_b;

  logic [9:0] duel_counter;

  // execute-stage values
  logic [1:0]        rrpv_old [NUM_WAYS];
  logic [1:0]        aged     [NUM_WAYS];
  logic [1:0]        inc;
  logic              has3;
  logic              has2;
  logic              has1;
  logic [PW-1:0]     pick;
  logic [ADDR_W-1:0] stride;
  logic [ADDR_W-1:0] prev_stride;
  logic [1:0]        cnt_old;
  logic [1:0]        cnt_new;
  logic              streaming;
  logic              brrip;
  logic              way_ok;
  logic [1:0]        upd_val;
  logic              evict_exec;
  logic              other_exec;

  // set index modulo the set count, restoring steps over shifted multiples
  always_comb begin
    set_rem = 20'(set_index);
    for (int k = 3; k >= 0; k--) begin
      if (set_rem >= (20'(NUM_SETS) << k)) set_rem = set_rem - (20'(NUM_SETS) << k);
    end
    set_addr = set_rem[SW-1:0];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr == SW'(NUM_SETS - 1));
  assign sts.out_busy   = out_valid && !out_ready;

  // execute kinds seen by the counter and the output checks
  assign evict_exec = cmd.exec && (req_r == REQ_EVICT);
  assign other_exec = cmd.exec && (req_r != REQ_VICTIM);

  // capture request and leader class
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      set_r  <= set_addr;
      way_r  <= way_index;
      addr_r <= phys_addr;
      hit_r  <= hit_flag;
      lead_s <= (32'(set_addr) < 32'(LEADER_COUNT));
      lead_b <= (32'(set_addr) >= 32'(LEADER_COUNT)) && (32'(set_addr) >= 32'(BRRIP_LO));
    end
  end

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= RESET_ROW;
    end else if (cmd.exec && row_wr) begin
      mem[set_r] <= row_new;
    end
    if (cmd.load) begin
      rd_row <= mem[set_addr];
    end
  end

  // victim aging and lowest way at max
  always_comb begin
    has3 = 1'b0;
    has2 = 1'b0;
    has1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv_old[w] = rd_row[2*w +: 2];
      has3 = has3 | (rrpv_old[w] == RRPV_MAX);
      has2 = has2 | (rrpv_old[w] == RRPV_LONG);
      has1 = has1 | (rrpv_old[w] == RRPV_NEAR);
    end
    priority if (has3) inc = 2'd0;
    else if (has2)     inc = 2'd1;
    else if (has1)     inc = 2'd2;
    else               inc = 2'd3;
    pick = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged[w] = rrpv_old[w] + inc;
      if (aged[w] == RRPV_MAX) pick = PW'(w);
    end
  end

  // stride stream detector and insertion value
  always_comb begin
    cnt_old     = rd_row[CNT_LO +: 2];
    prev_stride = rd_row[STR_LO +: ADDR_W];
    stride      = addr_r - rd_row[ADR_LO +: ADDR_W];
    if (prev_stride != '0 && stride == prev_stride) begin
      cnt_new = (cnt_old == 2'd3) ? cnt_old : cnt_old + 2'd1;
    end else begin
      cnt_new = (cnt_old == 2'd0) ? cnt_old : cnt_old - 2'd1;
    end
    streaming = cnt_new[1];
    priority if (lead_s) brrip = 1'b0;
    else if (lead_b)     brrip = 1'b1;
    else                 brrip = (duel_counter < DUEL_MID);
    priority if (hit_r)  upd_val = RRPV_HIT;
    else if (streaming)  upd_val = RRPV_MAX;
    else if (brrip)      upd_val = RRPV_LONG;
    else                 upd_val = RRPV_NEAR;
    way_ok = (32'(way_r) < 32'(NUM_WAYS));
  end

  // write-back row
  always_comb begin
    row_new = rd_row;
    row_wr  = 1'b0;
    unique case (req_r)
      REQ_VICTIM: begin
        row_wr = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) row_new[2*w +: 2] = aged[w];
      end
      REQ_UPDATE: begin
        row_wr = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (way_ok && 32'(way_r) == 32'(w)) row_new[2*w +: 2] = upd_val;
        end
        row_new[CNT_LO +: 2]      = cnt_new;
        row_new[STR_LO +: ADDR_W] = stride;
        row_new[ADR_LO +: ADDR_W] = addr_r;
      end
      default: begin
        row_wr = 1'b0;
      end
    endcase
  end

  // duel counter, saturating, moved by leader-set evictions
  always_ff @(posedge clk) begin
    if (rst) begin
      duel_counter <= DUEL_MID;
    end else if (evict_exec) begin
      if (lead_s) begin
        if (hit_r) begin
          if (duel_counter != DUEL_TOP) duel_counter <= duel_counter + 10'd1;
        end else if (duel_counter != '0) begin
          duel_counter <= duel_counter - 10'd1;
        end
      end else if (lead_b) begin
        if (hit_r) begin
          if (duel_counter != '0) duel_counter <= duel_counter - 10'd1;
        end else if (duel_counter != DUEL_TOP) begin
          duel_counter <= duel_counter + 10'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      victim_way  <= (req_r == REQ_VICTIM) ? 4'(pick) : 4'd0;
      stream_flag <= (req_r == REQ_UPDATE) ? streaming : 1'b0;
    end
  end

  // checks
  `DRRIP_ASSERT(a_exec_free, clk, rst, !(cmd.exec && sts.out_busy), "result overwritten")
  `DRRIP_ASSERT(a_clear_alone, clk, rst, !(cmd.clear_wr && (cmd.load || cmd.exec)), "load in clear")
  `DRRIP_ASSERT_NEXT(a_duel_hold, clk, rst, !evict_exec, $stable(duel_counter), "duel moved")
  `DRRIP_ASSERT_NEXT(a_victim_zero, clk, rst, other_exec, victim_way == 4'd0, "stray victim")

endmodule

`default_nettype wire

/* rtl/drrip_stream_bypass_replacement.sv */
// top level of the rrip replacement policy with stream detection
// depends on drrip_pkg, drrip_ctrl, drrip_dp
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  req_type set_index way_index phys_addr hit_flag
//   out      output     out_valid / out_ready victim_way stream_flag
//
// each request is accepted with the row read, then executed and written back
// the single-port row memory (one read and one write per request) sets that order
// after reset a clearing pass writes one set row per cycle, all NUM_SETS rows, in_ready low
// the result sits in an output register; a new request is taken while it waits
// execute stalls only while the previous result is still not taken
`default_nettype none

module drrip_stream_bypass_replacement
  import drrip_pkg::*;
#(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int LEADER_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [10:0] set_index,
  input  wire logic [3:0]  way_index,
  input  wire logic [63:0] phys_addr,
  input  wire logic        hit_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       victim_way,
  output logic             stream_flag
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  drrip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  drrip_dp #(
    .NUM_SETS     (NUM_SETS),
    .NUM_WAYS     (NUM_WAYS),
    .LEADER_COUNT (LEADER_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .set_index   (set_index),
    .way_index   (way_index),
    .phys_addr   (phys_addr),
    .hit_flag    (hit_flag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .victim_way  (victim_way),
    .stream_flag (stream_flag)
  );

endmodule

`default_nettype wire
